FILE: hdl/etac_pkg.sv
// shared types and constants of the elapsed timer with armed commands
// no dependencies; every other file imports this package
package etac_pkg;

	localparam int unsigned CLOCK_HZ_DEFAULT = 125000000;
	localparam int unsigned NS_PER_SEC       = 1000000000;

	localparam int OP_W    = 2;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int DIV_W   = 16;
	localparam int CNT_W   = 64;
	localparam int CFG_IDX_W = 1;

	// item opcodes
	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

	// register word addresses
	localparam logic [ADDR_W-1:0] ADDR_CAPT_LO   = 5'd0;
	localparam logic [ADDR_W-1:0] ADDR_CAPT_HI   = 5'd1;
	localparam logic [ADDR_W-1:0] ADDR_LOAD_LO   = 5'd2;
	localparam logic [ADDR_W-1:0] ADDR_LOAD_HI   = 5'd3;
	localparam logic [ADDR_W-1:0] ADDR_CMP_LO    = 5'd4;
	localparam logic [ADDR_W-1:0] ADDR_CMP_HI    = 5'd5;
	localparam logic [ADDR_W-1:0] ADDR_SNAP_LO   = 5'd6;
	localparam logic [ADDR_W-1:0] ADDR_SNAP_HI   = 5'd7;
	localparam logic [ADDR_W-1:0] ADDR_INTERVAL  = 5'd9;
	localparam logic [ADDR_W-1:0] ADDR_STATUS    = 5'd10;
	localparam logic [ADDR_W-1:0] ADDR_CONFIG    = 5'd12;
	localparam logic [ADDR_W-1:0] ADDR_ARM       = 5'd16;
	localparam logic [ADDR_W-1:0] ADDR_FIRE      = 5'd17;

	// command codes
	localparam logic [DATA_W-1:0] FIRE_CAPTURE = 32'h0000_01CD;
	localparam logic [DATA_W-1:0] FIRE_LOAD    = 32'h0000_02CD;
	localparam logic [DATA_W-1:0] FIRE_EVENT   = 32'h0000_03CD;
	localparam logic [DATA_W-1:0] FIRE_SYNC    = 32'h0000_04CD;
	localparam logic [DATA_W-1:0] ARM_CAPTURE  = 32'h0000_CD01;
	localparam logic [DATA_W-1:0] ARM_LOAD     = 32'h0000_CD02;
	localparam logic [DATA_W-1:0] ARM_EVENT    = 32'h0000_CD03;
	localparam logic [DATA_W-1:0] ARM_SYNC     = 32'h0000_CD04;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'b1;

	// which operands the shared divider works on
	typedef enum logic [1:0] {
		DIV_FREQ,
		DIV_STEP,
		DIV_SYNC
	} div_sel_t;

	typedef struct packed {
		logic     acc;
		logic     div_start;
		div_sel_t div_sel;
		logic     fin_step;
		logic     fin_sync;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
		logic sync_fire;
		logic div_write;
		logic cfg_div;
		logic div_done;
	} sts_t;

endpackage

FILE: hdl/etac_in_if.sv
// input channel of the timer: valid/ready plus one item
// depends on etac_pkg
interface etac_in_if import etac_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [ADDR_W-1:0] word_addr;
	logic [DATA_W-1:0] write_data;

	modport source (output valid, output op, output word_addr, output write_data,
		input ready);
	modport sink (input valid, input op, input word_addr, input write_data,
		output ready);
endinterface

FILE: hdl/etac_out_if.sv
// result channel of the timer: valid/ready plus one result
// depends on etac_pkg
interface etac_out_if import etac_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic              irq_line;
	logic              cmd_rejected;

	modport source (output valid, output read_data, output irq_line,
		output cmd_rejected, input ready);
	modport sink (input valid, input read_data, input irq_line,
		input cmd_rejected, output ready);
endinterface

FILE: hdl/etac_divider.sv
// bit-serial restoring divider, 64-bit dividend by 32-bit divisor
// depends on etac_pkg
module etac_divider import etac_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CNT_W-1:0]  dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic [CNT_W-1:0]  quo,
	output logic [DATA_W-1:0] rem,
	output logic              done
);
	localparam int ITER_W = $clog2(CNT_W + 1);

	logic [CNT_W-1:0]  dvd_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dsr_q;
	logic [ITER_W-1:0] iter_q;
	logic              done_q;
	logic [DATA_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, dvd_q[CNT_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (iter_q == ITER_W'(1));
			if (start) begin
				iter_q <= ITER_W'(CNT_W);
			end else if (iter_q != '0) begin
				iter_q <= iter_q - ITER_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (iter_q != '0) begin
			if (fits) begin
				rem_q <= DATA_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[DATA_W-1:0];
			end
			dvd_q <= {dvd_q[CNT_W-2:0], fits};
		end
	end

	assign quo  = dvd_q;
	assign rem  = rem_q;
	assign done = done_q;
endmodule

FILE: hdl/etac_datapath.sv
// timer registers, bus decode, result register and the shared divider
// depends on etac_pkg and etac_divider
module etac_datapath import etac_pkg::*; #(
	parameter int unsigned CLOCK_HZ = CLOCK_HZ_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic                 in_valid,
	input  logic [OP_W-1:0]      op,
	input  logic [ADDR_W-1:0]    word_addr,
	input  logic [DATA_W-1:0]    write_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DATA_W-1:0]    read_data,
	output logic                 irq_line,
	output logic                 cmd_rejected,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);
	localparam logic [DATA_W-1:0] STEP_RESET = DATA_W'(NS_PER_SEC / CLOCK_HZ);

	logic [CNT_W-1:0]  count_q, count_d;
	logic [DIV_W-1:0]  pre_q, pre_d;
	logic [DATA_W-1:0] step_q, step_d;
	logic [CNT_W-1:0]  capt_q, capt_d;
	logic [CNT_W-1:0]  load_q, load_d;
	logic [CNT_W-1:0]  cmp_q, cmp_d;
	logic              armed_q, armed_d;
	logic              flag_q, flag_d;
	logic [CNT_W-1:0]  snap_q, snap_d;
	logic [DATA_W-1:0] arm_q, arm_d;
	logic [DATA_W-1:0] fire_q, fire_d;
	logic [DIV_W-1:0]  div_q, div_d;
	logic [DATA_W-1:0] iv_q, iv_d;

	logic              out_valid_q;
	logic [DATA_W-1:0] rd_q, rd_d;
	logic              irq_q;
	logic              rej_q, rej_d;

	logic              is_fire;
	logic              hit_capture, hit_load, hit_event, hit_sync;
	logic              acc_plain;
	logic              out_load;
	logic [DATA_W-1:0] iv_eff;
	logic [DATA_W-1:0] freq;

	logic [CNT_W-1:0]  dv_dividend;
	logic [DATA_W-1:0] dv_divisor;
	logic [CNT_W-1:0]  dv_quo;
	logic [DATA_W-1:0] dv_rem;
	logic              dv_done;

	assign is_fire     = (op == OP_WRITE) && (word_addr == ADDR_FIRE);
	assign hit_capture = (write_data == FIRE_CAPTURE) && (arm_q == ARM_CAPTURE);
	assign hit_load    = (write_data == FIRE_LOAD) && (arm_q == ARM_LOAD);
	assign hit_event   = (write_data == FIRE_EVENT) && (arm_q == ARM_EVENT);
	assign hit_sync    = (write_data == FIRE_SYNC) && (arm_q == ARM_SYNC);

	assign sts.out_busy  = out_valid_q && !out_ready;
	assign sts.sync_fire = in_valid && is_fire && hit_sync;
	assign sts.div_write = in_valid && (op == OP_WRITE) && (word_addr == ADDR_CONFIG);
	assign sts.cfg_div   = cfg_we && (cfg_index == CFG_DIVIDER);
	assign sts.div_done  = dv_done;

	assign acc_plain = cmd.acc && !sts.sync_fire;
	assign out_load  = acc_plain || cmd.fin_sync;
	assign iv_eff    = (iv_q == '0) ? DATA_W'(1) : iv_q;
	assign freq      = (dv_quo == '0) ? DATA_W'(1) : dv_quo[DATA_W-1:0];

	always_comb begin
		count_d = count_q;
		pre_d   = pre_q;
		step_d  = step_q;
		capt_d  = capt_q;
		load_d  = load_q;
		cmp_d   = cmp_q;
		armed_d = armed_q;
		flag_d  = flag_q;
		snap_d  = snap_q;
		arm_d   = arm_q;
		fire_d  = fire_q;
		div_d   = div_q;
		iv_d    = iv_q;
		rd_d    = '0;
		rej_d   = 1'b0;

		if (acc_plain) begin
			unique case (op)
				OP_TICK: begin
					if (pre_q >= div_q) begin
						pre_d   = '0;
						count_d = count_q + CNT_W'(step_q);
					end else begin
						pre_d = pre_q + DIV_W'(1);
					end
				end
				OP_READ: begin
					unique case (word_addr)
						ADDR_CAPT_LO:  rd_d = capt_q[DATA_W-1:0];
						ADDR_CAPT_HI:  rd_d = capt_q[CNT_W-1:DATA_W];
						ADDR_LOAD_LO:  rd_d = load_q[DATA_W-1:0];
						ADDR_LOAD_HI:  rd_d = load_q[CNT_W-1:DATA_W];
						ADDR_CMP_LO:   rd_d = cmp_q[DATA_W-1:0];
						ADDR_CMP_HI:   rd_d = cmp_q[CNT_W-1:DATA_W];
						ADDR_SNAP_LO:  rd_d = snap_q[DATA_W-1:0];
						ADDR_SNAP_HI:  rd_d = snap_q[CNT_W-1:DATA_W];
						ADDR_INTERVAL: rd_d = iv_q;
						ADDR_STATUS:   rd_d = DATA_W'(flag_q);
						ADDR_CONFIG:   rd_d = DATA_W'({div_q, 3'b000});
						ADDR_ARM:      rd_d = arm_q;
						ADDR_FIRE:     rd_d = fire_q;
						default:       rd_d = '0;
					endcase
				end
				OP_WRITE: begin
					unique case (word_addr)
						ADDR_LOAD_LO:  load_d[DATA_W-1:0] = write_data;
						ADDR_LOAD_HI:  load_d[CNT_W-1:DATA_W] = write_data;
						ADDR_CMP_LO:   cmp_d[DATA_W-1:0] = write_data;
						ADDR_CMP_HI:   cmp_d[CNT_W-1:DATA_W] = write_data;
						ADDR_INTERVAL: iv_d = write_data;
						ADDR_STATUS: begin
							if (write_data[0]) flag_d = 1'b0;
							if (write_data[1]) snap_d = '0;
						end
						ADDR_CONFIG:   div_d = write_data[DIV_W+2:3];
						ADDR_ARM:      arm_d = write_data;
						ADDR_FIRE: begin
							fire_d = write_data;
							priority if (hit_capture) capt_d = count_q;
							else if (hit_load) count_d = load_q;
							else if (hit_event) armed_d = 1'b1;
							else rej_d = 1'b1;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end

		// sync fire: snapshot now, round up when the remainder is known
		if (cmd.acc && sts.sync_fire) begin
			snap_d = count_q;
			fire_d = write_data;
		end
		if (cmd.fin_sync) begin
			count_d = count_q + CNT_W'(iv_eff - dv_rem);
		end
		if (cmd.fin_step) begin
			step_d = dv_quo[DATA_W-1:0];
		end

		if (out_load && armed_d && (count_d >= cmp_d)) begin
			flag_d  = 1'b1;
			armed_d = 1'b0;
		end

		if (cfg_we) begin
			unique case (cfg_index)
				CFG_DIVIDER:  div_d = cfg_data[DIV_W-1:0];
				CFG_INTERVAL: iv_d = cfg_data;
				default: ;
			endcase
		end
	end

	// divider operands
	always_comb begin
		unique case (cmd.div_sel)
			DIV_FREQ: begin
				dv_dividend = CNT_W'(CLOCK_HZ);
				dv_divisor  = DATA_W'({1'b0, div_d} + (DIV_W + 1)'(1));
			end
			DIV_STEP: begin
				dv_dividend = CNT_W'(NS_PER_SEC);
				dv_divisor  = freq;
			end
			DIV_SYNC: begin
				dv_dividend = count_q;
				dv_divisor  = iv_eff;
			end
			default: begin
				dv_dividend = count_q;
				dv_divisor  = iv_eff;
			end
		endcase
	end

	etac_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dv_dividend),
		.divisor  (dv_divisor),
		.quo      (dv_quo),
		.rem      (dv_rem),
		.done     (dv_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pre_q       <= '0;
			step_q      <= STEP_RESET;
			capt_q      <= '0;
			load_q      <= '0;
			cmp_q       <= '0;
			armed_q     <= 1'b0;
			flag_q      <= 1'b0;
			snap_q      <= '0;
			arm_q       <= '0;
			fire_q      <= '0;
			div_q       <= '0;
			iv_q        <= DATA_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			pre_q   <= pre_d;
			step_q  <= step_d;
			capt_q  <= capt_d;
			load_q  <= load_d;
			cmp_q   <= cmp_d;
			armed_q <= armed_d;
			flag_q  <= flag_d;
			snap_q  <= snap_d;
			arm_q   <= arm_d;
			fire_q  <= fire_d;
			div_q   <= div_d;
			iv_q    <= iv_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rd_q  <= rd_d;
			irq_q <= flag_d;
			rej_q <= rej_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = rd_q;
	assign irq_line     = irq_q;
	assign cmd_rejected = rej_q;
endmodule

FILE: hdl/etac_ctrl.sv
// sequencer: item acceptance and the divider jobs for step and sync
// depends on etac_pkg
module etac_ctrl import etac_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_FREQ = 4'b0010,
		S_STEP = 4'b0100,
		S_SYNC = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd.acc       = 1'b0;
		cmd.div_start = 1'b0;
		cmd.div_sel   = DIV_FREQ;
		cmd.fin_step  = 1'b0;
		cmd.fin_sync  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = !sts.out_busy;
				cmd.acc  = in_valid && in_ready;
				priority if (cmd.acc && sts.sync_fire) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_SYNC;
					state_d       = S_SYNC;
				end else if ((cmd.acc && sts.div_write) || sts.cfg_div) begin
					cmd.div_start = 1'b1;
					state_d       = S_FREQ;
				end else begin
					state_d = state_q;
				end
			end
			S_FREQ: begin
				priority if (sts.cfg_div) begin
					cmd.div_start = 1'b1;
				end else if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_STEP;
					state_d       = S_STEP;
				end else begin
					state_d = state_q;
				end
			end
			S_STEP: begin
				priority if (sts.cfg_div) begin
					cmd.div_start = 1'b1;
					state_d       = S_FREQ;
				end else if (sts.div_done) begin
					cmd.fin_step = 1'b1;
					state_d      = S_IDLE;
				end else begin
					state_d = state_q;
				end
			end
			S_SYNC: begin
				cmd.div_sel = DIV_SYNC;
				if (sts.div_done) begin
					cmd.fin_sync = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

FILE: hdl/elapsed_timer_with_armed_commands.sv
// top level of the elapsed timer with armed commands
// depends on etac_pkg, etac_in_if, etac_out_if, etac_ctrl, etac_datapath

// A 64-bit nanosecond counter driven by tick beats, with a 32-bit register
// bus carried on the same input channel (op 0 tick, 1 read, 2 write). Every
// input beat yields exactly one result beat. For ticks, reads and most writes
// the result is registered and shows the cycle after the input beat is taken,
// and the next beat is taken at once unless the result is still stalled. A
// matched sync fire waits on the bit-serial divider that finds the counter's
// remainder by the round-up interval, one quotient bit a cycle. A write of
// the config register (word 12) or of configuration register 0 recomputes
// the step size with two passes through the same divider, during which no
// input beat is taken; its own result beat does not wait for them. Event
// compare, irq level and the command reject flag all reflect the state after
// the beat.
module elapsed_timer_with_armed_commands import etac_pkg::*; #(
	parameter int unsigned CLOCK_HZ = CLOCK_HZ_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	etac_in_if.sink              item,
	etac_out_if.source           result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);
	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	etac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// counter, registers, bus decode and the result register
	etac_datapath #(
		.CLOCK_HZ (CLOCK_HZ)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_valid     (item.valid),
		.op           (item.op),
		.word_addr    (item.word_addr),
		.write_data   (item.write_data),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.read_data    (result.read_data),
		.irq_line     (result.irq_line),
		.cmd_rejected (result.cmd_rejected),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);
endmodule

FILE: hdl/etac_checker.sv
// port-level checks of the elapsed timer with armed commands
// depends on etac_pkg; bound to the top level below
module etac_checker import etac_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [OP_W-1:0]   in_op,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DATA_W-1:0] out_read_data,
	input logic              out_irq,
	input logic              out_rej
);
	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_read_data)
			&& $stable(out_irq) && $stable(out_rej))
		else $error("result beat changed while stalled");

	// no new beat taken while a result is stuck
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !(out_valid && !out_ready))
		else $error("input beat taken over a stalled result");

	// ticks, reads and op three answer next cycle, never rejected
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_op != OP_WRITE) |=> out_valid && !out_rej)
		else $error("tick or read result missing or rejected");

	// a rejected command never carries read data
	a_rej_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_rej |-> out_read_data == '0)
		else $error("rejected beat with read data");
endmodule

bind elapsed_timer_with_armed_commands etac_checker u_etac_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (item.valid),
	.in_ready      (item.ready),
	.in_op         (item.op),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.out_read_data (result.read_data),
	.out_irq       (result.irq_line),
	.out_rej       (result.cmd_rejected)
);

FILE: sim/elapsed_timer_with_armed_commands_tb.sv
// self-checking testbench of the elapsed timer with armed commands
// depends on etac_pkg, etac_in_if, etac_out_if and the timer top level
`timescale 1ns / 1ps

module elapsed_timer_with_armed_commands_tb;
	import etac_pkg::*;

	localparam int WATCHDOG_LIMIT = 6000;
	// settle time for the step recompute after a divider change
	localparam int DIV_SETTLE = 300;

	typedef struct {
		logic [DATA_W-1:0] read_data;
		logic              irq_line;
		logic              cmd_rejected;
	} timer_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;

	etac_in_if  item ();
	etac_out_if result ();

	elapsed_timer_with_armed_commands i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item.sink),
		.result(result.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// mirror of the timer state
	logic [CNT_W-1:0]  tmr_count;
	logic [DIV_W-1:0]  tmr_prescale;
	logic [DATA_W-1:0] tmr_step;
	logic [CNT_W-1:0]  tmr_capture;
	logic [CNT_W-1:0]  tmr_load;
	logic [CNT_W-1:0]  tmr_cmp;
	logic              tmr_armed;
	logic              tmr_flag;
	logic [CNT_W-1:0]  tmr_snap;
	logic [DATA_W-1:0] tmr_arm_code;
	logic [DATA_W-1:0] tmr_fire_code;
	logic [DIV_W-1:0]  tmr_divider;
	logic [DATA_W-1:0] tmr_interval;

	timer_result_t pending_results[$];

	int src_idle_pct;
	int snk_stall_pct;
	int mismatches;
	int beats_in;
	int beats_out;
	int fires_matched;
	int events_hit;
	int idle_cycles;

	// ---------------------------------------------------------------
	// clock, reset, receiver stalls
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		result.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------
	function automatic logic [DATA_W-1:0] step_for_divider(input logic [DIV_W-1:0] dv);
		longint unsigned freq;
		freq = longint'(CLOCK_HZ_DEFAULT) / (longint'(dv) + 1);
		if (freq == 0)
			freq = 1;
		return DATA_W'(longint'(NS_PER_SEC) / freq);
	endfunction

	function automatic void timer_reset_state();
		tmr_count = '0;
		tmr_prescale = '0;
		tmr_capture = '0;
		tmr_load = '0;
		tmr_cmp = '0;
		tmr_armed = 1'b0;
		tmr_flag = 1'b0;
		tmr_snap = '0;
		tmr_arm_code = '0;
		tmr_fire_code = '0;
		tmr_divider = '0;
		tmr_interval = 32'd1;
		tmr_step = step_for_divider('0);
	endfunction

	// runs a fire write, returns 1 when the command is rejected
	function automatic logic timer_fire(input logic [DATA_W-1:0] code);
		logic [CNT_W-1:0] iv;
		if (code == FIRE_CAPTURE && tmr_arm_code == ARM_CAPTURE)
			tmr_capture = tmr_count;
		else if (code == FIRE_LOAD && tmr_arm_code == ARM_LOAD)
			tmr_count = tmr_load;
		else if (code == FIRE_EVENT && tmr_arm_code == ARM_EVENT)
			tmr_armed = 1'b1;
		else if (code == FIRE_SYNC && tmr_arm_code == ARM_SYNC) begin
			// round up to the next multiple of the interval, zero counts as one
			iv = (tmr_interval == 0) ? 64'd1 : CNT_W'(tmr_interval);
			tmr_snap = tmr_count;
			tmr_count = (tmr_count / iv + 64'd1) * iv;
		end else
			return 1'b1;
		fires_matched++;
		return 1'b0;
	endfunction

	function automatic logic [DATA_W-1:0] timer_read(input logic [ADDR_W-1:0] a);
		case (a)
			ADDR_CAPT_LO:  return tmr_capture[31:0];
			ADDR_CAPT_HI:  return tmr_capture[63:32];
			ADDR_LOAD_LO:  return tmr_load[31:0];
			ADDR_LOAD_HI:  return tmr_load[63:32];
			ADDR_CMP_LO:   return tmr_cmp[31:0];
			ADDR_CMP_HI:   return tmr_cmp[63:32];
			ADDR_SNAP_LO:  return tmr_snap[31:0];
			ADDR_SNAP_HI:  return tmr_snap[63:32];
			ADDR_INTERVAL: return tmr_interval;
			ADDR_STATUS:   return {31'd0, tmr_flag};
			ADDR_CONFIG:   return DATA_W'(tmr_divider) << 3;
			ADDR_ARM:      return tmr_arm_code;
			ADDR_FIRE:     return tmr_fire_code;
			default:       return '0;
		endcase
	endfunction

	// advances the mirror by one accepted beat and queues its result
	function automatic void timer_predict(input logic [OP_W-1:0] op,
		input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
		timer_result_t r;
		r.read_data = '0;
		r.cmd_rejected = 1'b0;
		if (op == OP_TICK) begin
			if (tmr_prescale >= tmr_divider) begin
				tmr_prescale = '0;
				tmr_count = tmr_count + CNT_W'(tmr_step);
			end else
				tmr_prescale = tmr_prescale + 1'b1;
		end else if (op == OP_READ)
			r.read_data = timer_read(a);
		else if (op == OP_WRITE) begin
			case (a)
				ADDR_LOAD_LO:  tmr_load[31:0] = d;
				ADDR_LOAD_HI:  tmr_load[63:32] = d;
				ADDR_CMP_LO:   tmr_cmp[31:0] = d;
				ADDR_CMP_HI:   tmr_cmp[63:32] = d;
				ADDR_INTERVAL: tmr_interval = d;
				ADDR_STATUS: begin
					if (d[0])
						tmr_flag = 1'b0;
					if (d[1])
						tmr_snap = '0;
				end
				ADDR_CONFIG: begin
					tmr_divider = d[18:3];
					tmr_step = step_for_divider(tmr_divider);
				end
				ADDR_ARM: tmr_arm_code = d;
				ADDR_FIRE: begin
					tmr_fire_code = d;
					r.cmd_rejected = timer_fire(d);
				end
				default: ;
			endcase
		end
		// armed compare is checked after every beat
		if (tmr_armed && tmr_count >= tmr_cmp) begin
			tmr_flag = 1'b1;
			tmr_armed = 1'b0;
			events_hit++;
		end
		r.irq_line = tmr_flag;
		pending_results.push_back(r);
	endfunction

	// ---------------------------------------------------------------
	// result checker and watchdog
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		timer_result_t want;
		if (arst_n && result.valid && result.ready) begin
			beats_out++;
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected: read_data %h", result.read_data);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (result.read_data !== want.read_data) begin
					$error("read_data expected %h actual %h", want.read_data, result.read_data);
					mismatches++;
				end
				if (result.irq_line !== want.irq_line) begin
					$error("irq_line expected %b actual %b", want.irq_line, result.irq_line);
					mismatches++;
				end
				if (result.cmd_rejected !== want.cmd_rejected) begin
					$error("cmd_rejected expected %b actual %b", want.cmd_rejected,
						result.cmd_rejected);
					mismatches++;
				end
			end
		end
	end

	// counts cycles in which neither channel moves a beat
	always @(posedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// shared driving tasks, entered and left at a falling edge
	// ---------------------------------------------------------------
	task automatic send_beat(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] a,
		input logic [DATA_W-1:0] d);
		while ($urandom_range(99) < src_idle_pct) begin
			item.valid = 1'b0;
			@(negedge clk);
		end
		item.valid = 1'b1;
		item.op = op;
		item.word_addr = a;
		item.write_data = d;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		timer_predict(op, a, d);
		beats_in++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item.valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// config writes only once the block has gone quiet
	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
		wait_drained();
		repeat (DIV_SETTLE) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_DIVIDER) begin
			tmr_divider = d[15:0];
			tmr_step = step_for_divider(tmr_divider);
		end else
			tmr_interval = d;
		repeat (DIV_SETTLE) @(negedge clk);
	endtask

	task automatic run_command(input logic [DATA_W-1:0] arm, input logic [DATA_W-1:0] code);
		send_beat(OP_WRITE, ADDR_ARM, arm);
		send_beat(OP_WRITE, ADDR_FIRE, code);
	endtask

	// ---------------------------------------------------------------
	// directed tests
	// ---------------------------------------------------------------
	task automatic test_reset_values();
		send_beat(OP_READ, ADDR_INTERVAL, '0);
		send_beat(OP_READ, ADDR_CONFIG, '0);
		send_beat(OP_TICK, '0, '0);
		send_beat(OP_TICK, '0, '0);
	endtask

	task automatic test_load_and_capture();
		// load near the top so a tick wraps the counter
		send_beat(OP_WRITE, ADDR_LOAD_LO, 32'hFFFF_FFFF);
		send_beat(OP_WRITE, ADDR_LOAD_HI, 32'hFFFF_FFFF);
		run_command(ARM_LOAD, FIRE_LOAD);
		send_beat(OP_TICK, '0, '0);
		run_command(ARM_CAPTURE, FIRE_CAPTURE);
		send_beat(OP_READ, ADDR_CAPT_LO, '0);
		// arm code stays stored, so a second fire still runs
		send_beat(OP_WRITE, ADDR_FIRE, FIRE_CAPTURE);
	endtask

	task automatic test_event_and_sync();
		send_beat(OP_WRITE, ADDR_CMP_HI, '0);
		send_beat(OP_WRITE, ADDR_CMP_LO, 32'd16);
		run_command(ARM_EVENT, FIRE_EVENT);
		send_beat(OP_WRITE, ADDR_INTERVAL, '0);
		run_command(ARM_SYNC, FIRE_SYNC);
		send_beat(OP_WRITE, ADDR_STATUS, 32'd3);
		// mismatched fire, op three, write to a read-only word
		run_command(ARM_LOAD, FIRE_SYNC);
		send_beat(2'd3, 5'd31, 32'hFFFF_FFFF);
		send_beat(OP_WRITE, ADDR_CAPT_LO, 32'h1234_5678);
	endtask

	// ---------------------------------------------------------------
	// random traffic
	// ---------------------------------------------------------------
	task automatic random_beat();
		logic [DATA_W-1:0] arm_codes[4];
		logic [DATA_W-1:0] fire_codes[4];
		logic [ADDR_W-1:0] writable[7];
		logic [CNT_W-1:0]  target;
		int k;
		int pick;
		arm_codes = '{ARM_CAPTURE, ARM_LOAD, ARM_EVENT, ARM_SYNC};
		fire_codes = '{FIRE_CAPTURE, FIRE_LOAD, FIRE_EVENT, FIRE_SYNC};
		writable = '{ADDR_LOAD_LO, ADDR_LOAD_HI, ADDR_CMP_LO, ADDR_CMP_HI,
			ADDR_INTERVAL, ADDR_STATUS, ADDR_ARM};
		pick = $urandom_range(99);
		k = $urandom_range(3);
		if (pick < 40)
			send_beat(OP_TICK, ADDR_W'($urandom), $urandom);
		else if (pick < 55)
			send_beat(OP_READ, ($urandom_range(9) == 0) ? ADDR_W'($urandom)
				: ADDR_W'($urandom_range(17)), '0);
		else if (pick < 63)
			send_beat(OP_WRITE, writable[$urandom_range(6)], $urandom);
		else if (pick < 67) begin
			// interval: zero, tiny, or anything
			case ($urandom_range(2))
				0: send_beat(OP_WRITE, ADDR_INTERVAL, '0);
				1: send_beat(OP_WRITE, ADDR_INTERVAL, $urandom_range(1, 100));
				default: send_beat(OP_WRITE, ADDR_INTERVAL, $urandom);
			endcase
		end else if (pick < 69)
			// divider mostly small so ticks keep moving the counter
			send_beat(OP_WRITE, ADDR_CONFIG, ($urandom_range(7) == 0) ? $urandom
				: {29'($urandom_range(3)), 3'($urandom)} | ($urandom & 32'hFFF8_0000));
		else if (pick < 71)
			send_beat(($urandom_range(1) == 0) ? 2'd3 : OP_WRITE,
				ADDR_W'($urandom_range(18, 31)), $urandom);
		else if (pick < 75)
			// sometimes clear the event flag, the snapshot or both
			send_beat(OP_WRITE, ADDR_STATUS, $urandom_range(3));
		else begin
			// command sequence, mostly well formed
			if (k == 1 && $urandom_range(1) == 0) begin
				target = ($urandom_range(3) == 0) ? 64'hFFFF_FFFF_FFFF_F000 | 64'($urandom)
					: {$urandom, $urandom};
				send_beat(OP_WRITE, ADDR_LOAD_LO, target[31:0]);
				send_beat(OP_WRITE, ADDR_LOAD_HI, target[63:32]);
			end else if (k == 2) begin
				target = tmr_count + 64'($urandom_range(3000));
				send_beat(OP_WRITE, ADDR_CMP_HI, target[63:32]);
				send_beat(OP_WRITE, ADDR_CMP_LO, target[31:0]);
			end
			if ($urandom_range(9) == 0)
				run_command(arm_codes[$urandom_range(3)], ($urandom_range(1) == 0)
					? fire_codes[$urandom_range(3)] : $urandom);
			else
				run_command(arm_codes[k], fire_codes[k]);
			if ($urandom_range(1) == 0)
				send_beat(OP_READ, ADDR_W'($urandom_range(17)), '0);
		end
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int beats);
		int stop_at;
		int pause_at;
		src_idle_pct = idle_pct;
		snk_stall_pct = stall_pct;
		stop_at = beats_in + beats;
		pause_at = beats_in + beats / 2;
		while (beats_in < stop_at) begin
			random_beat();
			// one hold-off per phase until everything has come back
			if (beats_in >= pause_at && pause_at != 0) begin
				wait_drained();
				pause_at = 0;
			end
			// short runs with no idling at all
			if ($urandom_range(49) == 0) begin
				src_idle_pct = 0;
				snk_stall_pct = 0;
				repeat (12) random_beat();
				src_idle_pct = idle_pct;
				snk_stall_pct = stall_pct;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// sequence of tests
	// ---------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DIVIDER;
		cfg_data = '0;
		item.valid = 1'b0;
		item.op = OP_TICK;
		item.word_addr = '0;
		item.write_data = '0;
		result.ready = 1'b0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		mismatches = 0;
		beats_in = 0;
		beats_out = 0;
		fires_matched = 0;
		events_hit = 0;
		idle_cycles = 0;
		timer_reset_state();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_values();
		test_load_and_capture();
		test_event_and_sync();

		// divider and interval at their extremes, then random settings
		write_cfg(CFG_DIVIDER, 32'd0);
		write_cfg(CFG_INTERVAL, 32'd1);
		test_random_phase(0, 0, 440);
		write_cfg(CFG_DIVIDER, 32'd65535);
		write_cfg(CFG_INTERVAL, 32'hFFFF_FFFF);
		test_random_phase(78, 0, 440);
		write_cfg(CFG_DIVIDER, $urandom_range(1, 5));
		write_cfg(CFG_INTERVAL, $urandom);
		test_random_phase(0, 78, 440);
		write_cfg(CFG_DIVIDER, 32'd0);
		write_cfg(CFG_INTERVAL, $urandom_range(1, 1000));
		test_random_phase(26, 26, 440);

		wait_drained();
		repeat (20) @(negedge clk);
		$display("sent %0d beats, checked %0d results", beats_in, beats_out);
		$display("matched commands %0d, event compares hit %0d", fires_matched, events_hit);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
